/* design/pcmo_pkg.sv */
`timescale 1ns / 1ps

package pcmo_pkg;

    localparam int COLOR_W   = 15;
    localparam int SOURCE_W  = 3;
    localparam int MASK_W    = 7;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [SOURCE_W-1:0] SRC_BACKDROP = 3'd6;
    localparam logic [SOURCE_W-1:0] SRC_NONE     = 3'd7;

    localparam logic [MODE_W-1:0] MODE_SINGLE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DOUBLE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HIRES      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HIRES_BLUR = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MATH_SUBTRACT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_SUB       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALVE         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_COLOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MASK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_OFF   = 3'd6;

    localparam logic [COLOR_W-1:0] LOW_BITS   = 15'h0421;
    localparam logic [16:0]        CARRY_BITS = 17'h08420;
    localparam logic [COLOR_W-1:0] HALF_MASK  = 15'h7bde;

    typedef struct packed {
        logic                   math_subtract;
        logic                   use_sub_screen;
        logic                   halve_enable;
        logic [COLOR_W-1:0]     fixed_color;
        logic [MASK_W-1:0]      source_enable_mask;
        logic [MODE_W-1:0]      output_mode;
        logic                   display_off;
    } t_cfg;

    typedef struct packed {
        logic [COLOR_W-1:0] first;
        logic [COLOR_W-1:0] second;
        logic               two;
        logic               blur;
        logic               line_start;
    } t_entry;

    function automatic logic [COLOR_W-1:0] pcmo_mix(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b,
        input logic               half,
        input logic               sub
    );
        logic [16:0] sum;
        logic [16:0] carry;
        logic [16:0] diff;
        logic [16:0] borrow;
        logic [16:0] r;
        sum    = {2'b00, a} + {2'b00, b};
        carry  = (sum - {2'b00, (a ^ b) & LOW_BITS}) & CARRY_BITS;
        diff   = {2'b00, a} - {2'b00, b} + CARRY_BITS;
        borrow = (diff - ({2'b00, a ^ b} & CARRY_BITS)) & CARRY_BITS;
        if (!sub) begin
            if (!half) begin
                r = (sum - carry) | (carry - (carry >> 5));
            end else begin
                r = (sum - {2'b00, (a ^ b) & LOW_BITS}) >> 1;
            end
        end else begin
            r = (diff - borrow) & (borrow - (borrow >> 5));
            if (half) begin
                r = {2'b00, r[COLOR_W-1:0] & HALF_MASK} >> 1;
            end
        end
        return r[COLOR_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] pcmo_avg(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b
    );
        return pcmo_mix(a, b, 1'b1, 1'b0);
    endfunction

    function automatic logic [COLOR_W-1:0] pcmo_pixel(
        input logic [SOURCE_W-1:0] src_a,
        input logic [COLOR_W-1:0]  col_a,
        input logic [SOURCE_W-1:0] src_b,
        input logic [COLOR_W-1:0]  col_b,
        input logic                win_main,
        input logic                win_math,
        input t_cfg                cfg
    );
        logic [COLOR_W-1:0] ca;
        logic [MASK_W:0]    en_mask;
        logic               en;
        ca      = win_main ? col_a : '0;
        en_mask = {1'b0, cfg.source_enable_mask};
        en      = (src_a != SRC_NONE) && en_mask[src_a];
        if (!win_math || !en) begin
            return ca;
        end else if (!cfg.use_sub_screen) begin
            return pcmo_mix(ca, cfg.fixed_color, cfg.halve_enable && win_main,
                            cfg.math_subtract);
        end else begin
            return pcmo_mix(ca, col_b,
                            cfg.halve_enable && win_main && (src_b != SRC_BACKDROP),
                            cfg.math_subtract);
        end
    endfunction

endpackage

/* design/pcmo_in_if.sv */
`timescale 1ns / 1ps

interface pcmo_in_if;
    import pcmo_pkg::*;

    logic                valid;
    logic                ready;
    logic [SOURCE_W-1:0] main_source;
    logic [COLOR_W-1:0]  main_color;
    logic [SOURCE_W-1:0] sub_source;
    logic [COLOR_W-1:0]  sub_color;
    logic                main_window;
    logic                sub_window;
    logic                line_start;

    modport source (
        output valid, main_source, main_color, sub_source, sub_color,
               main_window, sub_window, line_start,
        input  ready
    );

    modport sink (
        input  valid, main_source, main_color, sub_source, sub_color,
               main_window, sub_window, line_start,
        output ready
    );
endinterface

/* design/pcmo_out_if.sv */
`timescale 1ns / 1ps

interface pcmo_out_if;
    import pcmo_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] out_color;
    logic               last_of_pair;

    modport source (
        output valid, out_color, last_of_pair,
        input  ready
    );

    modport sink (
        input  valid, out_color, last_of_pair,
        output ready
    );
endinterface

/* design/pixel_color_math_output_core.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Payload
// i_pix     in   valid / ready    main_source, main_color, sub_source, sub_color,
//                                 main_window, sub_window, line_start
// o_pix     out  valid / ready    out_color, last_of_pair
// i_cfg_*   in   i_cfg_we         i_cfg_idx, i_cfg_data
//
// A column is sent as one beat in single mode and as two beats in the doubled and hires
// modes; the output register sends one beat per cycle while o_pix.ready is high.
// Color math sits in the front before a QUEUE_DEPTH-entry queue; blur and beat
// sequencing sit in the back. A pixel goes through the queue, then the output register.
// Reset is synchronous, active low, and clears the queue, the output and the blur history.
// A stalled output fills the queue, then drops i_pix.ready.

module pixel_color_math_output_core
    import pcmo_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pcmo_in_if.sink               i_pix,
    pcmo_out_if.source            o_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg   r_cfg;
    t_cfg   n_cfg;
    logic   q_ready;
    logic   push;
    t_entry push_entry;
    logic   q_valid;
    t_entry q_entry;
    logic   pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MATH_SUBTRACT: n_cfg.math_subtract      = i_cfg_data[0];
                REG_USE_SUB:       n_cfg.use_sub_screen     = i_cfg_data[0];
                REG_HALVE:         n_cfg.halve_enable       = i_cfg_data[0];
                REG_FIXED_COLOR:   n_cfg.fixed_color        = i_cfg_data[COLOR_W-1:0];
                REG_SOURCE_MASK:   n_cfg.source_enable_mask = i_cfg_data[MASK_W-1:0];
                REG_OUTPUT_MODE:   n_cfg.output_mode        = i_cfg_data[MODE_W-1:0];
                REG_DISPLAY_OFF:   n_cfg.display_off        = i_cfg_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pcmo_front u_front (
        .i_pix     (i_pix),
        .i_cfg     (r_cfg),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    pcmo_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_entry),
        .o_ready     (q_ready),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_entry)
    );

    pcmo_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .o_pix     (o_pix)
    );

endmodule

/* design/pcmo_front.sv */
`timescale 1ns / 1ps

module pcmo_front
    import pcmo_pkg::*;
(
    pcmo_in_if.sink i_pix,
    input  t_cfg    i_cfg,
    input  logic    i_q_ready,
    output logic    o_push,
    output t_entry  o_entry
);

    logic [COLOR_W-1:0] main_px;
    logic [COLOR_W-1:0] sub_px;

    assign i_pix.ready = i_q_ready;
    assign o_push      = i_pix.valid && i_q_ready;

    always_comb begin
        main_px = pcmo_pixel(i_pix.main_source, i_pix.main_color,
                             i_pix.sub_source, i_pix.sub_color,
                             i_pix.main_window, i_pix.sub_window, i_cfg);
        sub_px  = pcmo_pixel(i_pix.sub_source, i_pix.sub_color,
                             i_pix.main_source, i_pix.main_color,
                             i_pix.main_window, i_pix.sub_window, i_cfg);

        o_entry.two        = (i_cfg.output_mode != MODE_SINGLE);
        o_entry.blur       = (i_cfg.output_mode == MODE_HIRES_BLUR) && !i_cfg.display_off;
        o_entry.line_start = i_pix.line_start;

        if (i_cfg.display_off) begin
            o_entry.first  = '0;
            o_entry.second = '0;
        end else if (i_cfg.output_mode == MODE_SINGLE || i_cfg.output_mode == MODE_DOUBLE) begin
            o_entry.first  = main_px;
            o_entry.second = main_px;
        end else begin
            o_entry.first  = sub_px;
            o_entry.second = main_px;
        end
    end

endmodule

/* design/pcmo_queue.sv */
`timescale 1ns / 1ps

module pcmo_queue
    import pcmo_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_push_data,
    output logic   o_ready,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* design/pcmo_back.sv */
`timescale 1ns / 1ps

module pcmo_back
    import pcmo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_entry      i_q_entry,
    output logic        o_pop,
    pcmo_out_if.source  o_pix
);

    logic               r_out_valid;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_last;
    logic               r_pend_valid;
    logic [COLOR_W-1:0] r_pend_color;
    logic [COLOR_W-1:0] r_prev;

    logic               n_out_valid;
    logic [COLOR_W-1:0] n_out_color;
    logic               n_out_last;
    logic               n_pend_valid;
    logic [COLOR_W-1:0] n_pend_color;
    logic [COLOR_W-1:0] n_prev;

    logic               out_free;
    logic [COLOR_W-1:0] prev_eff;
    logic [COLOR_W-1:0] first_c;
    logic [COLOR_W-1:0] second_c;

    assign out_free = !r_out_valid || o_pix.ready;
    assign o_pop    = i_q_valid && out_free && !r_pend_valid;

    assign o_pix.valid        = r_out_valid;
    assign o_pix.out_color    = r_out_color;
    assign o_pix.last_of_pair = r_out_last;

    always_comb begin
        prev_eff = i_q_entry.line_start ? '0 : r_prev;
        first_c  = i_q_entry.blur ? pcmo_avg(prev_eff, i_q_entry.first) : i_q_entry.first;
        second_c = i_q_entry.blur ? pcmo_avg(i_q_entry.first, i_q_entry.second)
                                  : i_q_entry.second;

        n_out_valid  = r_out_valid;
        n_out_color  = r_out_color;
        n_out_last   = r_out_last;
        n_pend_valid = r_pend_valid;
        n_pend_color = r_pend_color;
        n_prev       = r_prev;

        if (out_free) begin
            if (r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out_color  = r_pend_color;
                n_out_last   = 1'b1;
                n_pend_valid = 1'b0;
            end else if (i_q_valid) begin
                n_out_valid  = 1'b1;
                n_out_color  = first_c;
                n_out_last   = !i_q_entry.two;
                n_pend_valid = i_q_entry.two;
                n_pend_color = second_c;
                if (i_q_entry.blur) begin
                    n_prev = i_q_entry.second;
                end else if (i_q_entry.line_start) begin
                    n_prev = '0;
                end
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_prev       <= '0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
            r_prev       <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_color  <= n_out_color;
        r_out_last   <= n_out_last;
        r_pend_color <= n_pend_color;
    end

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_out_valid && !r_out_last))
        else $error("second beat pending without first beat on output");

    a_pend_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && o_pix.ready) |=> (r_out_valid && r_out_last && !r_pend_valid))
        else $error("pending beat not advanced as last of pair");

    a_no_pop_while_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> !o_pop)
        else $error("queue popped while a second beat is pending");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pix.ready) |=> ($stable(r_out_color) && $stable(r_out_last)
                                           && $stable(r_pend_valid)))
        else $error("output beat changed while stalled");

endmodule
